/* rtl/core/cdqs_pkg.sv */
// Shared types and codes for the circular deque with search.
// No dependencies; imported by every module of the block.
`default_nettype none

package cdqs_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int WORD_W    = 32;
	localparam int POS_W     = 5;
	localparam int REQ_W     = 3;
	localparam int STAT_W    = 2;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 40;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_BACK  = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_SEARCH     = 3'd4,
		REQ_LIST       = 3'd5
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_EMPTY    = 2'd2,
		STAT_NOTFOUND = 2'd3
	} stat_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_REPORT
	} state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_ROT_L,
		CELL_SHIFT_R,
		CELL_LOAD_SEL
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [WORD_W-1:0]   wdata;
	} cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/cdqs_cell.sv */
// One storage cell of the deque chain: holds a word, takes a neighbor's word or, when selected, the write word.
// Depends on cdqs_pkg.
`default_nettype none

module cdqs_cell (
	input  wire                       clk,
	input  cdqs_pkg::cell_ctl_t       ctl,
	input  wire [cdqs_pkg::WORD_W-1:0] left_in,
	input  wire [cdqs_pkg::WORD_W-1:0] right_in,
	input  wire                       sel,
	output logic [cdqs_pkg::WORD_W-1:0] word
);
	import cdqs_pkg::*;

	logic [WORD_W-1:0] word_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_ROT_L:    word_q <= right_in;
			CELL_SHIFT_R:  word_q <= left_in;
			CELL_LOAD_SEL: if (sel) begin
				word_q <= ctl.wdata;
			end
			default:       word_q <= word_q;
		endcase
	end

	assign word = word_q;

endmodule

`default_nettype wire

/* rtl/core/cdqs_ctrl.sv */
// Request sequencer, entry count, scan counter and output register.
// Depends on cdqs_pkg; drives the cell chain through cell_ctl_t.
`default_nettype none

module cdqs_ctrl #(
	parameter int DEPTH = cdqs_pkg::DEPTH_DEF,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_tvalid,
	output logic                           s_tready,
	input  wire [cdqs_pkg::IN_DATA_W-1:0]  s_tdata,
	input  wire [cdqs_pkg::REQ_W-1:0]      s_tuser,
	output logic                           m_tvalid,
	input  wire                            m_tready,
	output logic [cdqs_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [cdqs_pkg::STAT_W-1:0]    m_tuser,
	output logic                           m_tlast,
	input  wire [cdqs_pkg::WORD_W-1:0]     head,
	output cdqs_pkg::cell_ctl_t            cell_ctl,
	output logic [CNT_W-1:0]               count
);
	import cdqs_pkg::*;

	state_t            state_q, state_n;
	logic [CNT_W-1:0]  count_q, count_n;
	logic [CNT_W-1:0]  step_q, step_n, step_inc;
	logic              is_list_q, is_list_n;
	logic [WORD_W-1:0] key_q, key_n;
	logic              found_q, found_n;
	logic [POS_W-1:0]  fpos_q, fpos_n;
	logic              out_valid_q, out_valid_n;
	stat_t             out_stat_q, out_stat_n;
	logic [POS_W-1:0]  out_pos_q, out_pos_n;
	logic [WORD_W-1:0] out_data_q, out_data_n;
	logic              out_last_q, out_last_n;
	logic              out_free, accept, full, empty, live, adv;
	req_t              req;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign step_inc = step_q + CNT_W'(1);
	assign live     = (step_q < count_q);
	assign req      = req_t'(s_tuser);

	always_comb begin
		state_n     = state_q;
		count_n     = count_q;
		step_n      = step_q;
		is_list_n   = is_list_q;
		key_n       = key_q;
		found_n     = found_q;
		fpos_n      = fpos_q;
		out_valid_n = out_valid_q && !m_tready;
		out_stat_n  = out_stat_q;
		out_pos_n   = out_pos_q;
		out_data_n  = out_data_q;
		out_last_n  = out_last_q;
		cell_ctl.op    = CELL_HOLD;
		cell_ctl.wdata = s_tdata[WORD_W-1:0];
		adv         = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					out_pos_n  = '0;
					out_data_n = '0;
					out_last_n = 1'b1;
					out_stat_n = STAT_OK;
					case (req)
						REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
							out_valid_n = 1'b1;
							if (full) begin
								out_stat_n = STAT_FULL;
							end else begin
								cell_ctl.op = (req == REQ_PUSH_FRONT) ? CELL_SHIFT_R
								                                     : CELL_LOAD_SEL;
								count_n = count_q + CNT_W'(1);
							end
						end
						REQ_POP_FRONT, REQ_POP_BACK: begin
							out_valid_n = 1'b1;
							if (empty) begin
								out_stat_n = STAT_EMPTY;
							end else begin
								if (req == REQ_POP_FRONT) begin
									cell_ctl.op = CELL_ROT_L;
								end
								count_n = count_q - CNT_W'(1);
							end
						end
						REQ_SEARCH, REQ_LIST: begin
							if (empty) begin
								out_valid_n = 1'b1;
								out_stat_n  = STAT_EMPTY;
							end else begin
								state_n   = S_SCAN;
								step_n    = '0;
								is_list_n = (req == REQ_LIST);
								key_n     = s_tdata[WORD_W-1:0];
								found_n   = 1'b0;
								fpos_n    = '0;
							end
						end
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				if (is_list_q) begin
					adv = !live || out_free;
					if (adv && live) begin
						out_valid_n = 1'b1;
						out_stat_n  = STAT_OK;
						out_pos_n   = POS_W'(step_inc);
						out_data_n  = head;
						out_last_n  = (step_inc == count_q);
					end
				end else begin
					adv = 1'b1;
					if (live && !found_q && head == key_q) begin
						found_n = 1'b1;
						fpos_n  = POS_W'(step_inc);
					end
				end
				if (adv) begin
					cell_ctl.op = CELL_ROT_L;
					step_n      = step_inc;
					if (step_q == CNT_W'(DEPTH - 1)) begin
						state_n = is_list_q ? S_IDLE : S_REPORT;
					end
				end
			end
			S_REPORT: begin
				if (out_free) begin
					out_valid_n = 1'b1;
					out_stat_n  = found_q ? STAT_OK : STAT_NOTFOUND;
					out_pos_n   = found_q ? fpos_q : '0;
					out_data_n  = '0;
					out_last_n  = 1'b1;
					state_n     = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			count_q     <= count_n;
			out_valid_q <= out_valid_n;
		end
	end

	always_ff @(posedge clk) begin
		step_q     <= step_n;
		is_list_q  <= is_list_n;
		key_q      <= key_n;
		found_q    <= found_n;
		fpos_q     <= fpos_n;
		out_stat_q <= out_stat_n;
		out_pos_q  <= out_pos_n;
		out_data_q <= out_data_n;
		out_last_q <= out_last_n;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_stat_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(OUT_DATA_W - POS_W - WORD_W){1'b0}}, out_data_q, out_pos_q};
	assign count    = count_q;

endmodule

`default_nettype wire

/* rtl/core/circular_deque_with_search.sv */
// Top level of the circular deque with search: a ring of cells plus sequencer.
// Depends on cdqs_pkg, cdqs_cell and cdqs_ctrl.
//
//   port group  dir  tdata                        tuser          tlast
//   s_*         in   value[31:0]                  req_type[2:0]  -
//   m_*         out  position[4:0], data[36:5]    status[1:0]    last
//
// Cell 0 holds the front entry whenever the sequencer is idle. Search and list
// rotate the whole ring once, through all DEPTH cells (search then reports from
// S_REPORT); a list step for a live entry waits while a result is held and m_tready is low.
// Reset clears the entry count and the sequencer; cell contents are not reset.
`default_nettype none

module circular_deque_with_search #(
	parameter int DEPTH = cdqs_pkg::DEPTH_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_tvalid,
	output logic                            s_tready,
	input  wire [cdqs_pkg::IN_DATA_W-1:0]   s_tdata,  // value
	input  wire [cdqs_pkg::REQ_W-1:0]       s_tuser,  // req_type
	output logic                            m_tvalid,
	input  wire                             m_tready,
	output logic [cdqs_pkg::OUT_DATA_W-1:0] m_tdata,  // position, data, zero pad
	output logic [cdqs_pkg::STAT_W-1:0]     m_tuser,  // status
	output logic                            m_tlast
);
	import cdqs_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	cell_ctl_t         cell_ctl;
	logic [CNT_W-1:0]  count;
	logic [WORD_W-1:0] words [DEPTH];

	cdqs_ctrl #(
		.DEPTH (DEPTH),
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.head     (words[0]),
		.cell_ctl (cell_ctl),
		.count    (count)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cdqs_cell u_cell (
			.clk      (clk),
			.ctl      (cell_ctl),
			.left_in  ((i == 0) ? cell_ctl.wdata : words[(i + DEPTH - 1) % DEPTH]),
			.right_in (words[(i + 1) % DEPTH]),
			.sel      (count == CNT_W'(i)),
			.word     (words[i])
		);
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == REQ_PUSH_FRONT || s_tuser == REQ_PUSH_BACK)
		 && count != CNT_W'(DEPTH)) |=> count == $past(count) + CNT_W'(1))
		else $error("push did not grow the count");

	a_push_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == REQ_PUSH_FRONT || s_tuser == REQ_PUSH_BACK
		 || s_tuser == REQ_POP_FRONT || s_tuser == REQ_POP_BACK)) |=> m_tvalid && m_tlast)
		else $error("push or pop gave no result");

	a_list_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == REQ_LIST && count == '0)
		|=> m_tvalid && m_tuser == STAT_EMPTY)
		else $error("list of empty store not reported");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Testbench for circular_deque_with_search: directed and random requests with a
// self-checking deque predictor and a result scoreboard. Depends on cdqs_pkg.
`default_nettype none

module tb_top;
	import cdqs_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam logic [REQ_W-1:0] REQ_RSVD_6 = 3'd6;
	localparam logic [REQ_W-1:0] REQ_RSVD_7 = 3'd7;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		stat_t             status;
		logic [POS_W-1:0]  pos;
		logic [WORD_W-1:0] data;
		logic              last;
	} deque_result_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic [REQ_W-1:0]      s_tuser  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STAT_W-1:0]     m_tuser;
	logic                  m_tlast;

	// predicted deque contents, front entry at ring_head
	logic [WORD_W-1:0] ring_model [DEPTH];
	int                ring_head  = 0;
	int                ring_count = 0;
	deque_result_t     pending_results [$];

	int mismatches   = 0;
	bit steady       = 1'b0;
	int hold_reqs    = 0;
	int hold_served  = 0;
	int hold_left    = 0;
	int quiet_cycles = 0;

	circular_deque_with_search #(.DEPTH(DEPTH)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // value
		.s_tuser  (s_tuser),   // req_type
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // position, data, zero pad
		.m_tuser  (m_tuser),   // status
		.m_tlast  (m_tlast)
	);

	always #10 clk = ~clk;

	function automatic void predict_request(input logic [REQ_W-1:0] code,
		input logic [WORD_W-1:0] word);
		deque_result_t r;
		int k;
		r.status = STAT_OK;
		r.pos    = '0;
		r.data   = '0;
		r.last   = 1'b1;
		case (code)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (ring_count >= DEPTH) begin
					r.status = STAT_FULL;
				end else if (code == REQ_PUSH_FRONT) begin
					ring_head = (ring_head + DEPTH - 1) % DEPTH;
					ring_model[ring_head] = word;
					ring_count++;
				end else begin
					ring_model[(ring_head + ring_count) % DEPTH] = word;
					ring_count++;
				end
			end
			REQ_POP_FRONT, REQ_POP_BACK: begin
				if (ring_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					if (code == REQ_POP_FRONT)
						ring_head = (ring_head + 1) % DEPTH;
					ring_count--;
				end
			end
			REQ_SEARCH: begin
				if (ring_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.status = STAT_NOTFOUND;
					for (k = 0; k < ring_count; k++) begin
						if (ring_model[(ring_head + k) % DEPTH] == word) begin
							r.status = STAT_OK;
							r.pos    = POS_W'(k + 1);
							break;
						end
					end
				end
			end
			REQ_LIST: begin
				if (ring_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					for (k = 0; k < ring_count; k++) begin
						r.pos  = POS_W'(k + 1);
						r.data = ring_model[(ring_head + k) % DEPTH];
						r.last = (k == ring_count - 1);
						pending_results.push_back(r);
					end
					return;
				end
			end
			default: return;
		endcase
		pending_results.push_back(r);
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(3))
			0: return $urandom();
			1: return $urandom_range(7);
			2: begin
				case ($urandom_range(3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'hFFFF_FFFF;
					default: return 32'h0000_0000;
				endcase
			end
			default: begin
				if (ring_count > 0)
					return ring_model[(ring_head + $urandom_range(ring_count - 1)) % DEPTH];
				return $urandom();
			end
		endcase
	endfunction

	task automatic send_req(input logic [REQ_W-1:0] code, input logic [WORD_W-1:0] word);
		int gap;
		gap = 0;
		if (!steady && $urandom_range(99) < 10)
			gap = $urandom_range(1, 3);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= code;
		s_tdata  <= word;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_request(code, word);
	endtask

	task automatic run_traffic(input int n_items, input int push_pct);
		int sent;
		int roll;
		logic [WORD_W-1:0] word;
		sent = 0;
		while (sent < n_items) begin
			roll = $urandom_range(99);
			word = pick_word();
			if (roll < 3) begin
				send_req($urandom_range(1) ? REQ_RSVD_7 : REQ_RSVD_6, word);
			end else begin
				if (roll < 80) begin
					if ($urandom_range(99) < push_pct)
						send_req($urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, word);
					else
						send_req($urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK, word);
				end else if (roll < 92) begin
					if (ring_count > 0 && $urandom_range(99) < 60)
						word = ring_model[(ring_head + $urandom_range(ring_count - 1)) % DEPTH];
					send_req(REQ_SEARCH, word);
				end else begin
					send_req(REQ_LIST, word);
				end
				sent++;
			end
		end
	endtask

	task automatic test_empty_store();
		send_req(REQ_POP_FRONT, 32'h0000_0000);
		send_req(REQ_POP_BACK, $urandom());
		send_req(REQ_SEARCH, 32'h0000_0000);
		send_req(REQ_LIST, 32'h0000_0000);
		send_req(REQ_RSVD_6, $urandom());
		send_req(REQ_RSVD_7, 32'hFFFF_FFFF);
	endtask

	task automatic test_extremes_and_full();
		int k;
		send_req(REQ_PUSH_BACK, 32'h7FFF_FFFF);
		send_req(REQ_PUSH_FRONT, 32'h8000_0000);
		send_req(REQ_PUSH_BACK, 32'hFFFF_FFFF);
		send_req(REQ_PUSH_FRONT, 32'h0000_0000);
		send_req(REQ_SEARCH, 32'hFFFF_FFFF);     // match on the back entry
		send_req(REQ_SEARCH, 32'h8000_0000);
		send_req(REQ_SEARCH, 32'h1234_5678);     // absent
		send_req(REQ_LIST, 32'h0000_0000);
		for (k = 0; k < 11; k++)
			send_req((k % 2) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, 32'h5A5A_0000 | k);
		send_req(REQ_PUSH_BACK, 32'h0000_0000);  // duplicate, store now full
		send_req(REQ_PUSH_FRONT, 32'h1111_1111);
		send_req(REQ_PUSH_BACK, 32'h2222_2222);
		send_req(REQ_LIST, 32'h0000_0000);
		send_req(REQ_SEARCH, 32'h0000_0000);     // first of two matches
		send_req(REQ_POP_FRONT, 32'h0000_0000);
		send_req(REQ_POP_BACK, 32'h0000_0000);
		send_req(REQ_LIST, 32'h0000_0000);
	endtask

	task automatic test_random_traffic();
		int p;
		for (p = 0; p < 8; p++)
			run_traffic(40, (p % 2) ? 25 : 80);
	endtask

	task automatic test_steady_stream();
		steady <= 1'b1;
		run_traffic(80, 55);
		steady <= 1'b0;
	endtask

	task automatic test_output_stall();
		hold_reqs <= hold_reqs + 1;
		run_traffic(60, 70);
	endtask

	task automatic report_mismatch(input string what, input logic [39:0] want,
		input logic [39:0] got);
		$display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
		mismatches++;
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_reqs) begin
			m_tready    <= 1'b0;
			hold_served <= hold_served + 1;
			hold_left   <= HOLD_CYCLES - 1;
		end else begin
			m_tready <= steady || ($urandom_range(99) >= 14);
		end
	end

	always @(posedge clk) begin : result_check
		deque_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with none pending", '0, m_tdata);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status)
					report_mismatch("status", want.status, m_tuser);
				if (m_tdata[4:0] !== want.pos)
					report_mismatch("position", want.pos, m_tdata[4:0]);
				if (m_tdata[36:5] !== want.data)
					report_mismatch("data", want.data, m_tdata[36:5]);
				if (m_tdata[39:37] !== 3'b000)
					report_mismatch("tdata pad", 3'b000, m_tdata[39:37]);
				if (m_tlast !== want.last)
					report_mismatch("last", want.last, m_tlast);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_store();
		test_extremes_and_full();
		test_random_traffic();
		test_steady_stream();
		test_output_stall();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
